>>> design/gjk_pkg.sv
// ----------------------------------------------------------------------------
// gjk_pkg: shared types and constants for the 2D GJK simplex step
// Field widths, result status codes, opcodes and the control word of the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gjk_pkg;

	// fixed item field widths
	localparam int InW = 16;
	localparam int DirW = 56;

	// default coordinate width (signed Q8.8)
	localparam int CoordWidthDef = 16;

	// opcode of an input item
	localparam logic OP_START = 1'b0;

	// result status
	typedef enum logic [1:0] {
		ST_EVOLVING         = 2'd0,
		ST_NOT_INTERSECTING = 2'd1,
		ST_INTERSECTING     = 2'd2,
		ST_IGNORED          = 2'd3
	} status_t;

	// control word of the multiply-accumulate unit
	typedef struct packed {
		logic en;   // update the accumulator
		logic clr;  // start a new sum
		logic neg;  // subtract the product
	} mac_ctl_t;

endpackage

`default_nettype wire

>>> design/gjk_in_if.sv
// ----------------------------------------------------------------------------
// gjk_in_if: input channel of the GJK simplex step
// Start items carry the centre offset, support items a Minkowski vertex.
// ----------------------------------------------------------------------------
`default_nettype none

interface gjk_in_if
	import gjk_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic signed [InW-1:0] vec_x;
	logic signed [InW-1:0] vec_y;

	modport source (output valid, output opcode, output vec_x, output vec_y, input ready);
	modport sink   (input valid, input opcode, input vec_x, input vec_y, output ready);
endinterface

`default_nettype wire

>>> design/gjk_out_if.sv
// ----------------------------------------------------------------------------
// gjk_out_if: result channel of the GJK simplex step
// Next search direction and test status, one item per input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gjk_out_if
	import gjk_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [DirW-1:0] dir_x;
	logic signed [DirW-1:0] dir_y;
	status_t                status;

	modport source (output valid, output dir_x, output dir_y, output status, input ready);
	modport sink   (input valid, input dir_x, input dir_y, input status, output ready);
endinterface

`default_nettype wire

>>> design/gjk_simplex_step_2d.sv
// ----------------------------------------------------------------------------
// gjk_simplex_step_2d: simplex update of one 2D GJK intersection test
// Appends support vertices, tests them against the search direction and
// advances the simplex (point, segment, triangle region test) with exact
// integer direction products computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//  channel | role   | payload                        | one item is
//  --------+--------+--------------------------------+----------------------------
//  req     | sink   | opcode, vec_x, vec_y           | a start offset or a vertex
//  rsp     | source | dir_x, dir_y, status           | the answer to one req item
//
//  A start or ignored item goes straight to the emit step; a support item runs
//  the dot test and stops there with one point or when the test fails, else
//  the segment step (two points) or the triangle region test follows (AB kept,
//  AC kept, or intersecting), on the single multiply-accumulate unit.
//  req.ready is high only while the sequencer is idle; the result register
//  lets the next item in while an answer still waits on rsp.
//  A stalled rsp holds the sequencer in its emit step until the register frees.
//  arst_n clears the sequencer and marks the test finished until a start item.
// ----------------------------------------------------------------------------
`default_nettype none

module gjk_simplex_step_2d
	import gjk_pkg::*;
#(
	parameter int COORD_WIDTH = CoordWidthDef
) (
	input wire logic clk,
	input wire logic arst_n,
	gjk_in_if.sink   req,
	gjk_out_if.source rsp
);

	localparam int C    = COORD_WIDTH;
	localparam int BW   = C + 1;            // coordinate differences
	localparam int SW   = 2 * C + 3;        // segment cross product
	localparam int AW   = DirW;
	localparam int ACCW = AW + BW + 1;
	localparam int RAWW = (C > InW) ? C : InW;

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_DOT_A   = 17'h00002,
		S_DOT_B   = 17'h00004,
		S_DOT_CHK = 17'h00008,
		S_CRS_A   = 17'h00010,
		S_CRS_B   = 17'h00020,
		S_CRS_LAT = 17'h00040,
		S_PERP_0  = 17'h00080,
		S_PERP_1  = 17'h00100,
		S_PERP_2  = 17'h00200,
		S_PERP_3  = 17'h00400,
		S_PERP_4  = 17'h00800,
		S_AB_B    = 17'h01000,
		S_AB_CHK  = 17'h02000,
		S_AC_B    = 17'h04000,
		S_AC_CHK  = 17'h08000,
		S_EMIT    = 17'h10000
	} state_t;

	function automatic logic signed [BW-1:0] ext_c(input logic signed [C-1:0] v);
		return {v[C-1], v};
	endfunction

	function automatic logic signed [AW-1:0] ext_b(input logic signed [BW-1:0] v);
		return {{(AW-BW){v[BW-1]}}, v};
	endfunction

	// control state
	state_t                 state_q;
	logic [1:0]             cnt_q;
	logic                   fin_q;
	status_t                status_q;
	logic signed [AW-1:0]   dir_x_q;
	logic signed [AW-1:0]   dir_y_q;
	logic                   out_valid_q;

	// payload state
	logic signed [C-1:0]    px_q [3];
	logic signed [C-1:0]    py_q [3];
	logic signed [C-1:0]    vx_q;
	logic signed [C-1:0]    vy_q;
	logic signed [SW-1:0]   s_q;
	logic signed [AW-1:0]   abp_x_q;
	logic signed [AW-1:0]   abp_y_q;
	logic signed [AW-1:0]   acp_x_q;
	logic signed [AW-1:0]   acp_y_q;
	logic signed [AW-1:0]   out_dir_x_q;
	logic signed [AW-1:0]   out_dir_y_q;
	status_t                out_status_q;

	// datapath wires
	logic [RAWW-1:0]        raw_x;
	logic [RAWW-1:0]        raw_y;
	logic signed [C-1:0]    in_x;
	logic signed [C-1:0]    in_y;
	logic                   seg;
	logic signed [BW-1:0]   ux;
	logic signed [BW-1:0]   uy;
	logic signed [BW-1:0]   wx;
	logic signed [BW-1:0]   wy;
	logic signed [BW-1:0]   neg_ax;
	logic signed [BW-1:0]   neg_ay;
	logic signed [AW-1:0]   s_ext;
	mac_ctl_t               mac_ctl;
	logic signed [AW-1:0]   op_a;
	logic signed [BW-1:0]   op_b;
	logic signed [ACCW-1:0] acc;
	logic                   acc_pos;
	logic signed [AW-1:0]   acc_dir;
	logic                   accept;
	logic                   emit;

	// input coordinates: low C bits of the zero-extended port value
	assign raw_x = RAWW'($unsigned(req.vec_x));
	assign raw_y = RAWW'($unsigned(req.vec_y));
	assign in_x  = $signed(raw_x[C-1:0]);
	assign in_y  = $signed(raw_y[C-1:0]);

	assign accept = req.valid && (state_q == S_IDLE);
	assign emit   = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	// edge vectors: segment (u = A-B, w = -B), triangle (u = AC, w = AB)
	always_comb begin
		seg    = (cnt_q == 2'd2);
		neg_ax = -ext_c(px_q[2]);
		neg_ay = -ext_c(py_q[2]);
		if (seg) begin
			ux = ext_c(px_q[1]) - ext_c(px_q[0]);
			uy = ext_c(py_q[1]) - ext_c(py_q[0]);
			wx = -ext_c(px_q[0]);
			wy = -ext_c(py_q[0]);
		end else begin
			ux = ext_c(px_q[0]) - ext_c(px_q[2]);
			uy = ext_c(py_q[0]) - ext_c(py_q[2]);
			wx = ext_c(px_q[1]) - ext_c(px_q[2]);
			wy = ext_c(py_q[1]) - ext_c(py_q[2]);
		end
	end

	assign s_ext = {{(AW-SW){s_q[SW-1]}}, s_q};

	// operand selection for the shared unit
	always_comb begin
		mac_ctl = '0;
		op_a    = '0;
		op_b    = '0;
		unique case (state_q)
			S_DOT_A: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
				op_a    = dir_x_q;
				op_b    = ext_c(vx_q);
			end
			S_DOT_B: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
				op_a    = dir_y_q;
				op_b    = ext_c(vy_q);
			end
			S_CRS_A: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
				op_a    = ext_b(ux);
				op_b    = wy;
			end
			S_CRS_B: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1};
				op_a    = ext_b(uy);
				op_b    = wx;
			end
			S_PERP_0: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b1};
				op_a    = s_ext;
				op_b    = seg ? uy : wy;
			end
			S_PERP_1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
				op_a    = s_ext;
				op_b    = seg ? ux : wx;
			end
			S_PERP_2: begin
				mac_ctl = '{en: !seg, clr: 1'b1, neg: 1'b0};
				op_a    = s_ext;
				op_b    = uy;
			end
			S_PERP_3: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b1};
				op_a    = s_ext;
				op_b    = ux;
			end
			S_PERP_4: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
				op_a    = abp_x_q;
				op_b    = neg_ax;
			end
			S_AB_B: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
				op_a    = abp_y_q;
				op_b    = neg_ay;
			end
			S_AB_CHK: begin
				mac_ctl = '{en: !acc_pos, clr: 1'b1, neg: 1'b0};
				op_a    = acp_x_q;
				op_b    = neg_ax;
			end
			S_AC_B: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
				op_a    = acp_y_q;
				op_b    = neg_ay;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	gjk_mac #(
		.A_W (AW),
		.B_W (BW)
	) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (op_a),
		.b   (op_b),
		.acc (acc)
	);

	assign acc_pos = !acc[ACCW-1] && (acc != '0);
	assign acc_dir = acc[AW-1:0];

	// sequencer and test state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 2'd0;
			fin_q       <= 1'b1;
			status_q    <= ST_EVOLVING;
			dir_x_q     <= '0;
			dir_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: filled on emit, freed when taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.opcode == OP_START) begin
							status_q <= ST_EVOLVING;
							cnt_q    <= 2'd0;
							fin_q    <= 1'b0;
							dir_x_q  <= {{(AW-C){in_x[C-1]}}, in_x};
							dir_y_q  <= {{(AW-C){in_y[C-1]}}, in_y};
							state_q  <= S_EMIT;
						end else if (fin_q || cnt_q == 2'd3) begin
							status_q <= ST_IGNORED;
							state_q  <= S_EMIT;
						end else begin
							status_q <= ST_EVOLVING;
							cnt_q    <= cnt_q + 2'd1;
							state_q  <= S_DOT_A;
						end
					end
				end
				S_DOT_A: state_q <= S_DOT_B;
				S_DOT_B: state_q <= S_DOT_CHK;
				S_DOT_CHK: begin
					if (!acc_pos) begin
						status_q <= ST_NOT_INTERSECTING;
						fin_q    <= 1'b1;
						state_q  <= S_EMIT;
					end else if (cnt_q == 2'd1) begin
						dir_x_q <= -dir_x_q;
						dir_y_q <= -dir_y_q;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_CRS_A;
					end
				end
				S_CRS_A:   state_q <= S_CRS_B;
				S_CRS_B:   state_q <= S_CRS_LAT;
				S_CRS_LAT: state_q <= S_PERP_0;
				S_PERP_0:  state_q <= S_PERP_1;
				S_PERP_1:  state_q <= S_PERP_2;
				S_PERP_2: begin
					if (seg) begin
						dir_x_q <= abp_x_q;
						dir_y_q <= acc_dir;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PERP_3;
					end
				end
				S_PERP_3: state_q <= S_PERP_4;
				S_PERP_4: state_q <= S_AB_B;
				S_AB_B:   state_q <= S_AB_CHK;
				S_AB_CHK: begin
					if (acc_pos) begin
						cnt_q   <= 2'd2;
						dir_x_q <= abp_x_q;
						dir_y_q <= abp_y_q;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_AC_B;
					end
				end
				S_AC_B: state_q <= S_AC_CHK;
				S_AC_CHK: begin
					if (acc_pos) begin
						cnt_q   <= 2'd2;
						dir_x_q <= acp_x_q;
						dir_y_q <= acp_y_q;
					end else begin
						status_q <= ST_INTERSECTING;
						fin_q    <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// simplex store, partial products and result payload
	always_ff @(posedge clk) begin
		if (accept && req.opcode != OP_START && !fin_q && cnt_q != 2'd3) begin
			px_q[cnt_q] <= in_x;
			py_q[cnt_q] <= in_y;
			vx_q        <= in_x;
			vy_q        <= in_y;
		end
		if (state_q == S_CRS_LAT) begin
			s_q <= acc[SW-1:0];
		end
		if (state_q == S_PERP_1) begin
			abp_x_q <= acc_dir;
		end
		if (state_q == S_PERP_2) begin
			abp_y_q <= acc_dir;
		end
		if (state_q == S_PERP_3) begin
			acp_x_q <= acc_dir;
		end
		if (state_q == S_PERP_4) begin
			acp_y_q <= acc_dir;
		end
		// region AB keeps B and A, region AC keeps C and A
		if (state_q == S_AB_CHK && acc_pos) begin
			px_q[0] <= px_q[1];
			py_q[0] <= py_q[1];
			px_q[1] <= px_q[2];
			py_q[1] <= py_q[2];
		end
		if (state_q == S_AC_CHK && acc_pos) begin
			px_q[1] <= px_q[2];
			py_q[1] <= py_q[2];
		end
		if (emit) begin
			out_status_q <= status_q;
			out_dir_x_q  <= (status_q == ST_EVOLVING) ? dir_x_q : '0;
			out_dir_y_q  <= (status_q == ST_EVOLVING) ? dir_y_q : '0;
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = out_valid_q;
	assign rsp.dir_x  = out_dir_x_q;
	assign rsp.dir_y  = out_dir_y_q;
	assign rsp.status = out_status_q;

endmodule

`default_nettype wire

>>> design/gjk_mac.sv
// ----------------------------------------------------------------------------
// gjk_mac: shared signed multiply-accumulate unit
// One product per cycle while enabled, added to or subtracted from the accumulator, or
// loaded as the start of a new sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gjk_mac
	import gjk_pkg::*;
#(
	parameter int A_W = DirW,
	parameter int B_W = CoordWidthDef + 1
) (
	input  wire logic                   clk,
	input  wire mac_ctl_t               ctl,
	input  wire logic signed [A_W-1:0]  a,
	input  wire logic signed [B_W-1:0]  b,
	output      logic signed [A_W+B_W:0] acc
);

	localparam int PROD_W = A_W + B_W;
	localparam int ACC_W  = PROD_W + 1;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	// product, sign-extended and optionally negated
	always_comb begin
		prod     = a * b;
		prod_ext = $signed({prod[PROD_W-1], prod});
		addend   = ctl.neg ? -prod_ext : prod_ext;
		base     = ctl.clr ? '0 : acc_q;
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + addend;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

>>> design/gjk_chk.sv
// ----------------------------------------------------------------------------
// gjk_chk: port-level checks of the GJK simplex step
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module gjk_chk
	import gjk_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   req_valid,
	input wire logic                   req_ready,
	input wire logic                   rsp_valid,
	input wire logic                   rsp_ready,
	input wire logic signed [DirW-1:0] rsp_dir_x,
	input wire logic signed [DirW-1:0] rsp_dir_y,
	input wire logic [1:0]             rsp_status
);

	// a pending result stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_dir_x) && $stable(rsp_dir_y)
			&& $stable(rsp_status))
		else $error("result payload changed while stalled");

	// one item at a time: ready drops after an accepted item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while another is in work");

	// final answers carry a zero direction
	a_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_EVOLVING |-> rsp_dir_x == '0 && rsp_dir_y == '0)
		else $error("final answer with nonzero direction");

endmodule

bind gjk_simplex_step_2d gjk_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_dir_x  (rsp.dir_x),
	.rsp_dir_y  (rsp.dir_y),
	.rsp_status (rsp.status)
);

`default_nettype wire
